>>> hdl/qrs_pkg.sv
// Package for the quadratic root solver: widths, status codes and side-band types.
// Used by every module of the block; depends on nothing.
package qrs_pkg;

    localparam int COEF_WIDTH = 16;                 // coefficient bits that are used
    localparam int FRAC_BITS  = 16;                 // fraction bits of the roots
    localparam int IN_W       = 16;                 // width of one coefficient field
    localparam int OUT_W      = 33;                 // width of one root field
    localparam int DMAG_W     = 2 * COEF_WIDTH + 1; // magnitude of a nonnegative discriminant
    localparam int DISC_W     = 2 * COEF_WIDTH + 2; // signed discriminant
    localparam int ROOT_BITS  = (DMAG_W + 2 * FRAC_BITS + 1) / 2;
    localparam int RAD_W      = 2 * ROOT_BITS;
    localparam int NUM_W      = ((ROOT_BITS > COEF_WIDTH + FRAC_BITS) ?
                                 ROOT_BITS : COEF_WIDTH + FRAC_BITS) + 2;
    localparam int DEN_W      = COEF_WIDTH + 1;
    localparam int S_DATA_W   = ((3 * IN_W + 7) / 8) * 8;
    localparam int M_DATA_W   = ((2 * OUT_W + 2 + 7) / 8) * 8;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_NEG_DISC = 2'd1,
        STAT_A_ZERO   = 2'd2
    } status_t;

    typedef struct packed {
        status_t                       status;
        logic signed [COEF_WIDTH-1:0]  a;
        logic signed [COEF_WIDTH-1:0]  b;
    } sqrt_side_t;

    typedef struct packed {
        status_t status;
        logic    neg;
    } div_side_t;

endpackage

>>> hdl/qrs_disc.sv
// Discriminant pipeline: register coefficients, multiply, subtract and classify.
// Depends on qrs_pkg.
module qrs_disc (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  ce,
    input  logic                                  in_valid,
    input  logic signed [qrs_pkg::COEF_WIDTH-1:0] a,
    input  logic signed [qrs_pkg::COEF_WIDTH-1:0] b,
    input  logic signed [qrs_pkg::COEF_WIDTH-1:0] c,
    output logic                                  out_valid,
    output logic [qrs_pkg::DMAG_W-1:0]            dmag,
    output qrs_pkg::sqrt_side_t                   side
);

    localparam int CW = qrs_pkg::COEF_WIDTH;

    logic [2:0]                 v_reg;
    logic signed [CW-1:0]       a1_reg, b1_reg, c1_reg;
    logic signed [CW-1:0]       a2_reg, b2_reg;
    logic signed [2*CW-1:0]     bb_reg, ac_reg;
    logic signed [qrs_pkg::DISC_W-1:0] disc_next;
    logic [qrs_pkg::DMAG_W-1:0] dmag_reg;
    qrs_pkg::sqrt_side_t        side_reg, side_next;

    always_comb
    begin
        disc_next = qrs_pkg::DISC_W'(bb_reg) - (qrs_pkg::DISC_W'(ac_reg) <<< 2);
        side_next.a = a2_reg;
        side_next.b = b2_reg;
        if (a2_reg == '0)
            side_next.status = qrs_pkg::STAT_A_ZERO;
        else if (disc_next < 0)
            side_next.status = qrs_pkg::STAT_NEG_DISC;
        else
            side_next.status = qrs_pkg::STAT_OK;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (ce)
            v_reg <= {v_reg[1:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            a1_reg   <= a;
            b1_reg   <= b;
            c1_reg   <= c;
            bb_reg   <= b1_reg * b1_reg;
            ac_reg   <= a1_reg * c1_reg;
            a2_reg   <= a1_reg;
            b2_reg   <= b1_reg;
            side_reg <= side_next;
            // a negative discriminant is flagged; its root is never used
            dmag_reg <= disc_next[qrs_pkg::DISC_W-1] ? '0 : disc_next[qrs_pkg::DMAG_W-1:0];
        end
    end

    assign out_valid = v_reg[2];
    assign dmag      = dmag_reg;
    assign side      = side_reg;

endmodule

>>> hdl/qrs_sqrt.sv
// Pipelined square root, one root bit per stage, of the discriminant scaled by 4^FRAC_BITS.
// Depends on qrs_pkg.
module qrs_sqrt (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              ce,
    input  logic                              in_valid,
    input  logic [qrs_pkg::DMAG_W-1:0]        dmag,
    input  qrs_pkg::sqrt_side_t               in_side,
    output logic                              out_valid,
    output logic [qrs_pkg::ROOT_BITS-1:0]     root,
    output qrs_pkg::sqrt_side_t               out_side
);

    localparam int RB = qrs_pkg::ROOT_BITS;
    localparam int RW = qrs_pkg::RAD_W;

    logic                v_q    [RB+1];
    logic [RB+1:0]       rem_q  [RB+1];
    logic [RB-1:0]       root_q [RB+1];
    logic [RW-1:0]       rad_q  [RB+1];
    qrs_pkg::sqrt_side_t side_q [RB+1];

    assign v_q[0]    = in_valid;
    assign rem_q[0]  = '0;
    assign root_q[0] = '0;
    assign rad_q[0]  = RW'(dmag) << (2 * qrs_pkg::FRAC_BITS);
    assign side_q[0] = in_side;

    for (genvar k = 0; k < RB; k++)
    begin : g_stage
        logic [RB+3:0] rem_sh;
        logic [RB+3:0] trial;
        logic          ge;
        logic [RB+1:0] rem_next;
        logic [RB-1:0] root_next;
        logic          v_reg;
        logic [RB+1:0] rem_reg;
        logic [RB-1:0] root_reg;
        logic [RW-1:0] rad_reg;
        qrs_pkg::sqrt_side_t side_reg;

        always_comb
        begin
            rem_sh    = {rem_q[k], rad_q[k][RW-1 -: 2]};
            trial     = (RB+4)'({root_q[k], 2'b01});
            ge        = rem_sh >= trial;
            rem_next  = ge ? (RB+2)'(rem_sh - trial) : rem_sh[RB+1:0];
            root_next = {root_q[k][RB-2:0], ge};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg <= 1'b0;
            else if (ce)
                v_reg <= v_q[k];
        end

        always_ff @(posedge clk)
        begin
            if (ce)
            begin
                rem_reg  <= rem_next;
                root_reg <= root_next;
                rad_reg  <= rad_q[k] << 2;
                side_reg <= side_q[k];
            end
        end

        assign v_q[k+1]    = v_reg;
        assign rem_q[k+1]  = rem_reg;
        assign root_q[k+1] = root_reg;
        assign rad_q[k+1]  = rad_reg;
        assign side_q[k+1] = side_reg;
    end

    assign out_valid = v_q[RB];
    assign root      = root_q[RB];
    assign out_side  = side_q[RB];

endmodule

>>> hdl/qrs_div.sv
// Pipelined restoring divider on magnitudes, one quotient bit per stage.
// Depends on qrs_pkg.
module qrs_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          ce,
    input  logic                          in_valid,
    input  logic [qrs_pkg::NUM_W-1:0]     num,
    input  logic [qrs_pkg::DEN_W-1:0]     den,
    input  qrs_pkg::div_side_t            in_side,
    output logic                          out_valid,
    output logic [qrs_pkg::NUM_W-1:0]     quot,
    output qrs_pkg::div_side_t            out_side
);

    localparam int NW = qrs_pkg::NUM_W;
    localparam int DW = qrs_pkg::DEN_W;

    logic               v_q    [NW+1];
    logic [NW-1:0]      nq_q   [NW+1];
    logic [DW-1:0]      rem_q  [NW+1];
    logic [DW-1:0]      den_q  [NW+1];
    qrs_pkg::div_side_t side_q [NW+1];

    assign v_q[0]    = in_valid;
    assign nq_q[0]   = num;
    assign rem_q[0]  = '0;
    assign den_q[0]  = den;
    assign side_q[0] = in_side;

    for (genvar k = 0; k < NW; k++)
    begin : g_stage
        logic [DW:0]   rem_sh;
        logic          ge;
        logic [DW-1:0] rem_next;
        logic          v_reg;
        logic [NW-1:0] nq_reg;
        logic [DW-1:0] rem_reg;
        logic [DW-1:0] den_reg;
        qrs_pkg::div_side_t side_reg;

        always_comb
        begin
            rem_sh   = {rem_q[k], nq_q[k][NW-1]};
            ge       = rem_sh >= {1'b0, den_q[k]};
            rem_next = ge ? DW'(rem_sh - {1'b0, den_q[k]}) : rem_sh[DW-1:0];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg <= 1'b0;
            else if (ce)
                v_reg <= v_q[k];
        end

        // shift the dividend out at the top, the quotient bit in at the bottom
        always_ff @(posedge clk)
        begin
            if (ce)
            begin
                nq_reg   <= {nq_q[k][NW-2:0], ge};
                rem_reg  <= rem_next;
                den_reg  <= den_q[k];
                side_reg <= side_q[k];
            end
        end

        assign v_q[k+1]    = v_reg;
        assign nq_q[k+1]   = nq_reg;
        assign rem_q[k+1]  = rem_reg;
        assign den_q[k+1]  = den_reg;
        assign side_q[k+1] = side_reg;
    end

    assign out_valid = v_q[NW];
    assign quot      = nq_q[NW];
    assign out_side  = side_q[NW];

endmodule

>>> hdl/quadratic_root_solver.sv
// Top level of the quadratic root solver: discriminant, square root, two dividers,
// saturation and the output register. Depends on qrs_pkg, qrs_disc, qrs_sqrt, qrs_div.
//
// channel  | direction | contents
// s_*      | in        | coef_a, coef_b, coef_c
// m_*      | out       | root_plus, root_minus, status
//
// One transaction per cycle in while the output is not stalled, one result per
// transaction out; the pipeline depth is set by the one-bit-per-stage square
// root and dividers.
// Reset clears only the valid bits. A stalled output freezes the whole pipeline;
// s_tready is high whenever the output register is empty or being taken.
module quadratic_root_solver (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [qrs_pkg::S_DATA_W-1:0]    s_tdata,  // coef_a, coef_b, coef_c
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [qrs_pkg::M_DATA_W-1:0]    m_tdata   // root_plus, root_minus, status
);

    localparam int CW = qrs_pkg::COEF_WIDTH;
    localparam int IW = qrs_pkg::IN_W;
    localparam int RB = qrs_pkg::ROOT_BITS;
    localparam int NW = qrs_pkg::NUM_W;
    localparam int DW = qrs_pkg::DEN_W;
    localparam int OW = qrs_pkg::OUT_W;
    localparam logic [NW-1:0] POS_LIM = NW'(1) << (OW - 1);

    logic                ce;
    logic                m_valid_reg;
    logic [qrs_pkg::M_DATA_W-1:0] m_data_reg, m_data_next;

    logic                d_valid;
    logic [qrs_pkg::DMAG_W-1:0] d_mag;
    qrs_pkg::sqrt_side_t d_side;

    logic                q_valid;
    logic [RB-1:0]       q_root;
    qrs_pkg::sqrt_side_t q_side;

    logic signed [NW-1:0] base, num_p, num_m;
    logic                 n_valid_reg;
    logic [NW-1:0]        mag_p_reg, mag_m_reg;
    logic [DW-1:0]        den_reg;
    qrs_pkg::div_side_t   side_p_reg, side_m_reg;

    logic                 dp_valid, dm_valid;
    logic [NW-1:0]        quot_p, quot_m;
    qrs_pkg::div_side_t   dp_side, dm_side;
    logic [OW-1:0]        root_p, root_m;

    assign ce       = !m_valid_reg || m_tready;
    assign s_tready = ce;

    qrs_disc u_disc (
        .clk       (clk),
        .rst_n     (rst_n),
        .ce        (ce),
        .in_valid  (s_tvalid),
        .a         (s_tdata[CW-1:0]),
        .b         (s_tdata[IW +: CW]),
        .c         (s_tdata[2*IW +: CW]),
        .out_valid (d_valid),
        .dmag      (d_mag),
        .side      (d_side)
    );

    qrs_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .ce        (ce),
        .in_valid  (d_valid),
        .dmag      (d_mag),
        .in_side   (d_side),
        .out_valid (q_valid),
        .root      (q_root),
        .out_side  (q_side)
    );

    // numerators -b*2^F +/- s, signs and magnitudes
    always_comb
    begin
        base  = -(NW'(q_side.b) <<< qrs_pkg::FRAC_BITS);
        num_p = base + NW'(q_root);
        num_m = base - NW'(q_root);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            n_valid_reg <= 1'b0;
        else if (ce)
            n_valid_reg <= q_valid;
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            mag_p_reg         <= num_p[NW-1] ? -num_p : num_p;
            mag_m_reg         <= num_m[NW-1] ? -num_m : num_m;
            den_reg           <= q_side.a[CW-1] ? -(DW'(q_side.a) <<< 1) : (DW'(q_side.a) <<< 1);
            side_p_reg.status <= q_side.status;
            side_p_reg.neg    <= num_p[NW-1] ^ q_side.a[CW-1];
            side_m_reg.status <= q_side.status;
            side_m_reg.neg    <= num_m[NW-1] ^ q_side.a[CW-1];
        end
    end

    qrs_div u_div_plus (
        .clk       (clk),
        .rst_n     (rst_n),
        .ce        (ce),
        .in_valid  (n_valid_reg),
        .num       (mag_p_reg),
        .den       (den_reg),
        .in_side   (side_p_reg),
        .out_valid (dp_valid),
        .quot      (quot_p),
        .out_side  (dp_side)
    );

    qrs_div u_div_minus (
        .clk       (clk),
        .rst_n     (rst_n),
        .ce        (ce),
        .in_valid  (n_valid_reg),
        .num       (mag_m_reg),
        .den       (den_reg),
        .in_side   (side_m_reg),
        .out_valid (dm_valid),
        .quot      (quot_m),
        .out_side  (dm_side)
    );

    // apply sign with saturation; zero the roots unless the status is clean
    always_comb
    begin
        if (dp_side.neg)
            root_p = (quot_p > POS_LIM) ? OW'(-POS_LIM) : OW'(-quot_p);
        else
            root_p = (quot_p > POS_LIM - NW'(1)) ? OW'(POS_LIM - NW'(1)) : OW'(quot_p);
        if (dm_side.neg)
            root_m = (quot_m > POS_LIM) ? OW'(-POS_LIM) : OW'(-quot_m);
        else
            root_m = (quot_m > POS_LIM - NW'(1)) ? OW'(POS_LIM - NW'(1)) : OW'(quot_m);
        if (dp_side.status != qrs_pkg::STAT_OK)
        begin
            root_p = '0;
            root_m = '0;
        end
        m_data_next = qrs_pkg::M_DATA_W'({dp_side.status, root_m, root_p});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if (ce)
            m_valid_reg <= dp_valid && dm_valid;
    end

    always_ff @(posedge clk)
    begin
        if (ce)
            m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule
